>>> rtl/qsc_pkg.sv
// Shared constants, operand tables and pipeline enable type for the quad shape classifier.
`default_nettype none

package qsc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int NUM_CORNERS    = 4;

    // Coordinate differences formed in the diff stage: corner HI minus corner LO.
    localparam int NUM_DIFF = 8;
    localparam int DI_E0    = 0;   // corner 1 - corner 0
    localparam int DI_E1    = 1;   // corner 2 - corner 1
    localparam int DI_E2    = 2;   // corner 3 - corner 2
    localparam int DI_E3    = 3;   // corner 0 - corner 3
    localparam int DI_L     = 4;   // corner 2 - corner 0
    localparam int DI_Q3    = 5;   // corner 3 - corner 0
    localparam int DI_M     = 6;   // corner 0 - corner 2
    localparam int DI_N     = 7;   // corner 1 - corner 3

    localparam int DIFF_HI [NUM_DIFF] = '{1, 2, 3, 0, 2, 3, 0, 1};
    localparam int DIFF_LO [NUM_DIFF] = '{0, 1, 2, 3, 0, 0, 2, 3};

    // Cross products a.x*b.y - a.y*b.x.
    localparam int NUM_CROSS = 12;
    localparam int CI_T0  = 0;    // turn at corner 1
    localparam int CI_T1  = 1;    // turn at corner 2
    localparam int CI_T2  = 2;    // turn at corner 3
    localparam int CI_T3  = 3;    // turn at corner 0
    localparam int CI_S1  = 4;    // side of corner 1 against line 0-2
    localparam int CI_S3  = 5;    // side of corner 3 against line 0-2
    localparam int CI_D1  = 6;    // denominator, edges 0-1 and 2-3
    localparam int CI_N11 = 7;
    localparam int CI_N12 = 8;
    localparam int CI_D2  = 9;    // denominator, edges 1-2 and 3-0
    localparam int CI_N21 = 10;
    localparam int CI_N22 = 11;

    localparam int CROSS_A [NUM_CROSS] = '{
        DI_E0, DI_E1, DI_E2, DI_E3, DI_L, DI_L,
        DI_E0, DI_E0, DI_E2, DI_E1, DI_E1, DI_E3
    };
    localparam int CROSS_B [NUM_CROSS] = '{
        DI_E1, DI_E2, DI_E3, DI_E0, DI_E0, DI_Q3,
        DI_E2, DI_M, DI_M, DI_E3, DI_N, DI_N
    };

    typedef struct packed {
        logic diff;
        logic mul;
        logic sub;
        logic res;
    } t_pipe_en;

endpackage

`default_nettype wire

>>> rtl/qsc_cross.sv
// Two-stage signed cross product: registered partial products, then registered difference.
`default_nettype none

module qsc_cross #(
    parameter int COORD_BITS = qsc_pkg::COORD_BITS_DEF
) (
    input  wire                            i_clk,
    input  qsc_pkg::t_pipe_en              i_en,
    input  wire  signed [COORD_BITS:0]     i_ax,
    input  wire  signed [COORD_BITS:0]     i_ay,
    input  wire  signed [COORD_BITS:0]     i_bx,
    input  wire  signed [COORD_BITS:0]     i_by,
    output logic signed [2*COORD_BITS+2:0] o_cross
);
    import qsc_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int CW = PW + 1;

    logic signed [PW-1:0] r_p_ab;
    logic signed [PW-1:0] r_p_ba;
    logic signed [PW-1:0] n_p_ab;
    logic signed [PW-1:0] n_p_ba;
    logic signed [CW-1:0] r_cross;
    logic signed [CW-1:0] n_cross;

    always_comb begin
        n_p_ab  = PW'(i_ax) * PW'(i_by);
        n_p_ba  = PW'(i_ay) * PW'(i_bx);
        n_cross = CW'(r_p_ab) - CW'(r_p_ba);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_p_ab <= n_p_ab;
            r_p_ba <= n_p_ba;
        end
        if (i_en.sub) begin
            r_cross <= n_cross;
        end
    end

    assign o_cross = r_cross;

endmodule

`default_nettype wire

>>> rtl/qsc_flags.sv
// Sign and range tests on the cross products, producing the registered result flags.
`default_nettype none

module qsc_flags #(
    parameter int COORD_BITS = qsc_pkg::COORD_BITS_DEF
) (
    input  wire                            i_clk,
    input  qsc_pkg::t_pipe_en              i_en,
    input  wire  signed [2*COORD_BITS+2:0] i_cross [qsc_pkg::NUM_CROSS],
    input  wire                            i_degenerate,
    output logic                           o_degenerate,
    output logic                           o_simple,
    output logic                           o_convex,
    output logic                           o_split_diag
);
    import qsc_pkg::*;

    localparam int CW = 2 * COORD_BITS + 3;

    logic r_degenerate;
    logic r_simple;
    logic r_convex;
    logic r_split_diag;
    logic n_simple;
    logic n_convex;
    logic n_split_diag;
    logic cross_a;
    logic cross_b;

    function automatic logic f_pos(input logic signed [CW-1:0] v);
        return !v[CW-1] && (v != '0);
    endfunction

    function automatic logic f_opposite(input logic signed [CW-1:0] a,
                                        input logic signed [CW-1:0] b);
        return (f_pos(a) && b[CW-1]) || (a[CW-1] && f_pos(b));
    endfunction

    // n/d within [0,1] for nonzero d, without forming the quotient
    function automatic logic f_in_unit(input logic signed [CW-1:0] n,
                                       input logic signed [CW-1:0] d);
        logic res;
        if (d[CW-1]) begin
            res = (n[CW-1] || (n == '0)) && (n >= d);
        end else begin
            res = !n[CW-1] && (n <= d);
        end
        return res;
    endfunction

    always_comb begin
        cross_a = (i_cross[CI_D1] != '0)
                  && f_in_unit(i_cross[CI_N11], i_cross[CI_D1])
                  && f_in_unit(i_cross[CI_N12], i_cross[CI_D1]);
        cross_b = (i_cross[CI_D2] != '0)
                  && f_in_unit(i_cross[CI_N21], i_cross[CI_D2])
                  && f_in_unit(i_cross[CI_N22], i_cross[CI_D2]);
        n_simple = !cross_a && !cross_b;
        n_convex = !f_opposite(i_cross[CI_T0], i_cross[CI_T1])
                   && !f_opposite(i_cross[CI_T1], i_cross[CI_T2])
                   && !f_opposite(i_cross[CI_T2], i_cross[CI_T3]);
        n_split_diag = (f_pos(i_cross[CI_S1]) && f_pos(i_cross[CI_S3]))
                       || (i_cross[CI_S1][CW-1] && i_cross[CI_S3][CW-1]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.res) begin
            r_degenerate <= i_degenerate;
            r_simple     <= n_simple;
            r_convex     <= n_convex;
            r_split_diag <= n_split_diag;
        end
    end

    assign o_degenerate = r_degenerate;
    assign o_simple     = r_simple;
    assign o_convex     = r_convex;
    assign o_split_diag = r_split_diag;

endmodule

`default_nettype wire

>>> rtl/quad_shape_classifier.sv
// Top level of the quad shape classifier: input register, difference stage, cross units, flags.
//
// Usage:
//   Input channel: one word is four corners (i_corner*_x, i_corner*_y), signed,
//   COORD_BITS wide. A word is taken at a rising edge with i_valid high and
//   o_stall low.
//   Output channel: one word of four flags (o_degenerate, o_simple, o_convex,
//   o_split_diag) per input word, in order, taken at an edge with o_valid high
//   and i_stall low.
//   Path: an accepted word reaches o_valid through the input register,
//   the difference register, the product register of the 24 multipliers, the
//   cross product register and the flag register.
//   Throughput: one quad per cycle while i_stall is low; each pipeline register holds one word.
//   Stall: a held-off output keeps its flags; stages behind it keep filling
//   until full, then o_stall rises. Up to five words are in flight.
//   Reset (i_rst_n low, synchronous) empties the pipeline and drops o_valid.
`default_nettype none

module quad_shape_classifier #(
    parameter int COORD_BITS = qsc_pkg::COORD_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire  signed [COORD_BITS-1:0] i_corner0_x,
    input  wire  signed [COORD_BITS-1:0] i_corner0_y,
    input  wire  signed [COORD_BITS-1:0] i_corner1_x,
    input  wire  signed [COORD_BITS-1:0] i_corner1_y,
    input  wire  signed [COORD_BITS-1:0] i_corner2_x,
    input  wire  signed [COORD_BITS-1:0] i_corner2_y,
    input  wire  signed [COORD_BITS-1:0] i_corner3_x,
    input  wire  signed [COORD_BITS-1:0] i_corner3_y,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic                        o_degenerate,
    output logic                        o_simple,
    output logic                        o_convex,
    output logic                        o_split_diag
);
    import qsc_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int CW = 2 * DW + 1;

    logic signed [COORD_BITS-1:0] r_x [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] r_y [NUM_CORNERS];
    logic signed [DW-1:0]         r_dx [NUM_DIFF];
    logic signed [DW-1:0]         r_dy [NUM_DIFF];
    logic signed [DW-1:0]         n_dx [NUM_DIFF];
    logic signed [DW-1:0]         n_dy [NUM_DIFF];
    logic signed [CW-1:0]         cross_prod [NUM_CROSS];

    logic r_v_in;
    logic r_v_diff;
    logic r_v_mul;
    logic r_v_sub;
    logic r_v_res;
    logic en_in;
    logic n_deg;
    logic r_deg_diff;
    logic r_deg_mul;
    logic r_deg_sub;
    t_pipe_en en;

    // advance a stage when it is empty or the next one advances
    always_comb begin
        en.res  = !r_v_res || !i_stall;
        en.sub  = !r_v_sub || en.res;
        en.mul  = !r_v_mul || en.sub;
        en.diff = !r_v_diff || en.mul;
        en_in   = !r_v_in || en.diff;
    end

    assign o_stall = !en_in;
    assign o_valid = r_v_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in   <= 1'b0;
            r_v_diff <= 1'b0;
            r_v_mul  <= 1'b0;
            r_v_sub  <= 1'b0;
            r_v_res  <= 1'b0;
        end else begin
            if (en_in) begin
                r_v_in <= i_valid;
            end
            if (en.diff) begin
                r_v_diff <= r_v_in;
            end
            if (en.mul) begin
                r_v_mul <= r_v_diff;
            end
            if (en.sub) begin
                r_v_sub <= r_v_mul;
            end
            if (en.res) begin
                r_v_res <= r_v_sub;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_x[0] <= i_corner0_x;
            r_y[0] <= i_corner0_y;
            r_x[1] <= i_corner1_x;
            r_y[1] <= i_corner1_y;
            r_x[2] <= i_corner2_x;
            r_y[2] <= i_corner2_y;
            r_x[3] <= i_corner3_x;
            r_y[3] <= i_corner3_y;
        end
    end

    for (genvar d = 0; d < NUM_DIFF; d++) begin : g_diff
        assign n_dx[d] = DW'(r_x[DIFF_HI[d]]) - DW'(r_x[DIFF_LO[d]]);
        assign n_dy[d] = DW'(r_y[DIFF_HI[d]]) - DW'(r_y[DIFF_LO[d]]);
    end

    assign n_deg = (r_x[0] == r_x[1]) && (r_y[0] == r_y[1]);

    always_ff @(posedge i_clk) begin
        if (en.diff) begin
            r_dx       <= n_dx;
            r_dy       <= n_dy;
            r_deg_diff <= n_deg;
        end
        if (en.mul) begin
            r_deg_mul <= r_deg_diff;
        end
        if (en.sub) begin
            r_deg_sub <= r_deg_mul;
        end
    end

    for (genvar g = 0; g < NUM_CROSS; g++) begin : g_cross
        qsc_cross #(
            .COORD_BITS(COORD_BITS)
        ) u_cross (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_ax   (r_dx[CROSS_A[g]]),
            .i_ay   (r_dy[CROSS_A[g]]),
            .i_bx   (r_dx[CROSS_B[g]]),
            .i_by   (r_dy[CROSS_B[g]]),
            .o_cross(cross_prod[g])
        );
    end

    qsc_flags #(
        .COORD_BITS(COORD_BITS)
    ) u_flags (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_cross     (cross_prod),
        .i_degenerate(r_deg_sub),
        .o_degenerate(o_degenerate),
        .o_simple    (o_simple),
        .o_convex    (o_convex),
        .o_split_diag(o_split_diag)
    );

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for quad_shape_classifier: directed table, random quads, flag predictor.
module tb;

    localparam int CB             = qsc_pkg::COORD_BITS_DEF;
    localparam int NUM_RANDOM     = 400;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [3:0][CB-1:0] x;
        logic [3:0][CB-1:0] y;
    } t_quad;

    typedef struct packed {
        logic degenerate;
        logic simple;
        logic convex;
        logic split_diag;
    } t_shape_flags;

    typedef struct packed {
        t_quad        q;
        logic         typed;
        t_shape_flags flags;
    } t_dir_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_stall = 1'b0;
    logic [CB-1:0] i_corner0_x = '0;
    logic [CB-1:0] i_corner0_y = '0;
    logic [CB-1:0] i_corner1_x = '0;
    logic [CB-1:0] i_corner1_y = '0;
    logic [CB-1:0] i_corner2_x = '0;
    logic [CB-1:0] i_corner2_y = '0;
    logic [CB-1:0] i_corner3_x = '0;
    logic [CB-1:0] i_corner3_y = '0;
    logic          o_stall;
    logic          o_valid;
    logic          o_degenerate;
    logic          o_simple;
    logic          o_convex;
    logic          o_split_diag;

    t_shape_flags pending_flags[$];
    t_dir_row     dir_rows[$];
    int           errors = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           quiet_cycles = 0;

    quad_shape_classifier dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_corner0_x  (i_corner0_x),
        .i_corner0_y  (i_corner0_y),
        .i_corner1_x  (i_corner1_x),
        .i_corner1_y  (i_corner1_y),
        .i_corner2_x  (i_corner2_x),
        .i_corner2_y  (i_corner2_y),
        .i_corner3_x  (i_corner3_x),
        .i_corner3_y  (i_corner3_y),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_degenerate (o_degenerate),
        .o_simple     (o_simple),
        .o_convex     (o_convex),
        .o_split_diag (o_split_diag)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint cross2d(input longint ax, input longint ay,
                                       input longint bx, input longint by);
        return ax * by - ay * bx;
    endfunction

    function automatic int sign_of(input longint v);
        if (v < 0) return -1;
        if (v > 0) return 1;
        return 0;
    endfunction

    function automatic bit param_in_unit(input longint n, input longint d);
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        return (n >= 0) && (n <= d);
    endfunction

    function automatic bit edges_meet(input longint ax, input longint ay,
                                      input longint bx, input longint by,
                                      input longint cx, input longint cy,
                                      input longint ex, input longint ey);
        longint s1x, s1y, s2x, s2y, ox, oy, d;
        s1x = bx - ax;
        s1y = by - ay;
        s2x = ex - cx;
        s2y = ey - cy;
        ox  = ax - cx;
        oy  = ay - cy;
        d   = cross2d(s1x, s1y, s2x, s2y);
        if (d == 0) return 1'b0;
        return param_in_unit(cross2d(s1x, s1y, ox, oy), d) &&
               param_in_unit(cross2d(s2x, s2y, ox, oy), d);
    endfunction

    function automatic t_shape_flags classify_quad(input t_quad q);
        longint       x[4];
        longint       y[4];
        int           turn[4];
        int           j;
        int           k;
        int           s1;
        int           s3;
        longint       lx;
        longint       ly;
        t_shape_flags f;
        for (int i = 0; i < 4; i++) begin
            x[i] = $signed(q.x[i]);
            y[i] = $signed(q.y[i]);
        end
        f.convex = 1'b1;
        for (int i = 0; i < 4; i++) begin
            j = (i + 1) % 4;
            k = (i + 2) % 4;
            turn[i] = sign_of(cross2d(x[j] - x[i], y[j] - y[i], x[k] - x[j], y[k] - y[j]));
            if (i > 0 && turn[i] * turn[i-1] < 0) f.convex = 1'b0;
        end
        lx = x[2] - x[0];
        ly = y[2] - y[0];
        s1 = sign_of(cross2d(lx, ly, x[1] - x[0], y[1] - y[0]));
        s3 = sign_of(cross2d(lx, ly, x[3] - x[0], y[3] - y[0]));
        f.degenerate = (x[0] == x[1]) && (y[0] == y[1]);
        f.simple = !edges_meet(x[0], y[0], x[1], y[1], x[2], y[2], x[3], y[3]) &&
                   !edges_meet(x[1], y[1], x[2], y[2], x[3], y[3], x[0], y[0]);
        f.split_diag = (s1 * s3 > 0);
        return f;
    endfunction

    function automatic t_quad rand_quad();
        int    cx[4];
        int    cy[4];
        int    kind;
        int    bx;
        int    by;
        t_quad q;
        kind = $urandom_range(99);
        bx = $urandom_range(65535) - 32768;
        by = $urandom_range(65535) - 32768;
        for (int i = 0; i < 4; i++) begin
            if (kind < 30) begin
                cx[i] = $urandom();
                cy[i] = $urandom();
            end else if (kind < 55 || kind >= 88) begin
                cx[i] = $urandom_range(8) - 4;
                cy[i] = $urandom_range(8) - 4;
            end else if (kind < 75) begin
                cx[i] = bx + $urandom_range(128) - 64;
                cy[i] = by + $urandom_range(128) - 64;
            end else begin
                case ($urandom_range(6))
                    0: cx[i] = -32768;
                    1: cx[i] = -32767;
                    2: cx[i] = -1;
                    3: cx[i] = 0;
                    4: cx[i] = 1;
                    5: cx[i] = 32766;
                    default: cx[i] = 32767;
                endcase
                case ($urandom_range(6))
                    0: cy[i] = -32768;
                    1: cy[i] = -32767;
                    2: cy[i] = -1;
                    3: cy[i] = 0;
                    4: cy[i] = 1;
                    5: cy[i] = 32766;
                    default: cy[i] = 32767;
                endcase
            end
        end
        if (kind >= 88) begin
            case ($urandom_range(2))
                0: begin
                    cx[1] = cx[0];
                    cy[1] = cy[0];
                end
                1: begin
                    cx[2] = cx[0];
                    cy[2] = cy[0];
                end
                default: begin
                    cx[1] = 2 * cx[1];
                    cy[1] = 2 * cy[1];
                    cx[3] = (cx[0] + cx[1]) / 2;
                    cy[3] = (cy[0] + cy[1]) / 2;
                end
            endcase
        end
        for (int i = 0; i < 4; i++) begin
            q.x[i] = cx[i][CB-1:0];
            q.y[i] = cy[i][CB-1:0];
        end
        return q;
    endfunction

    task automatic add_row(input int x0, input int y0, input int x1, input int y1,
                           input int x2, input int y2, input int x3, input int y3,
                           input logic typed, input logic [3:0] f);
        t_dir_row r;
        r.q.x[0] = x0[CB-1:0];
        r.q.y[0] = y0[CB-1:0];
        r.q.x[1] = x1[CB-1:0];
        r.q.y[1] = y1[CB-1:0];
        r.q.x[2] = x2[CB-1:0];
        r.q.y[2] = y2[CB-1:0];
        r.q.x[3] = x3[CB-1:0];
        r.q.y[3] = y3[CB-1:0];
        r.typed = typed;
        r.flags = f;
        dir_rows.push_back(r);
    endtask

    task automatic send_quad(input t_quad q, input t_shape_flags want);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_corner0_x <= q.x[0];
        i_corner0_y <= q.y[0];
        i_corner1_x <= q.x[1];
        i_corner1_y <= q.y[1];
        i_corner2_x <= q.x[2];
        i_corner2_y <= q.y[2];
        i_corner3_x <= q.x[3];
        i_corner3_y <= q.y[3];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_flags.push_back(want);
    endtask

    task automatic check_flag(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_shape_flags want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_flags.size() == 0) begin
                $error("flags word with no quad waiting");
                errors++;
            end else begin
                want = pending_flags.pop_front();
                check_flag("degenerate", want.degenerate, o_degenerate);
                check_flag("simple", want.simple, o_simple);
                check_flag("convex", want.convex, o_convex);
                check_flag("split_diag", want.split_diag, o_split_diag);
            end
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_shape_flags want;
        t_quad        q;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 4'b1110);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b1, 4'b1110);
        add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b1, 4'b1110);
        add_row(0, 0, 1, 0, 1, 1, 0, 1, 1'b1, 4'b0110);
        add_row(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767, 1'b1, 4'b0110);
        add_row(0, 0, 0, 1, 1, 1, 1, 0, 1'b0, 4'b0000);
        add_row(0, 0, 1, 0, 0, 1, 1, 1, 1'b0, 4'b0000);
        add_row(0, 0, 4, 0, 4, 4, 2, 0, 1'b0, 4'b0000);
        add_row(0, 0, 4, 0, 6, 0, 2, 0, 1'b0, 4'b0000);
        add_row(0, 0, 4, 0, 3, 2, 1, 2, 1'b0, 4'b0000);
        add_row(0, 0, 4, 2, 0, 4, 1, 2, 1'b0, 4'b0000);
        add_row(0, 0, 1, 1, 2, 2, 0, 2, 1'b0, 4'b0000);
        add_row(0, 0, 3, 1, 0, 0, 1, 3, 1'b0, 4'b0000);
        add_row(5, 5, 5, 5, 9, 1, 2, 7, 1'b0, 4'b0000);
        add_row(0, 0, 2, 0, 4, 0, 2, 3, 1'b0, 4'b0000);
        add_row(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767, 1'b0, 4'b0000);
        add_row(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846, 1'b0, 4'b0000);
        add_row(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767, 1'b0, 4'b0000);
        add_row(0, 0, 0, 0, 0, 0, 7, -3, 1'b0, 4'b0000);

        foreach (dir_rows[r]) begin
            want = dir_rows[r].typed ? dir_rows[r].flags : classify_quad(dir_rows[r].q);
            send_quad(dir_rows[r].q, want);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 78;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 78;
                end
                default: begin
                    idle_pct  = 31;
                    stall_pct = 31;
                end
            endcase
            for (int n = 0; n < NUM_RANDOM; n++) begin
                q = rand_quad();
                send_quad(q, classify_quad(q));
            end
        end
        i_valid <= 1'b0;

        while (pending_flags.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> quad_shape_classifier.f
rtl/qsc_pkg.sv
rtl/qsc_cross.sv
rtl/qsc_flags.sv
rtl/quad_shape_classifier.sv
tb/tb.sv
